/* rtl/bds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants for the 4x4 box downsampler: channel sums,
// result record, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package bds_pkg;

  // Default line store depth and frame height limit
  localparam int DEF_MAX_OUT_WIDTH  = 256;
  localparam int DEF_MAX_OUT_HEIGHT = 1024;

  // Supersampling factor is fixed at 4: sub-position counters are 2 bits
  localparam int               SS_W    = 2;
  localparam logic [SS_W-1:0]  SS_LAST = 2'd3;
  localparam logic [SS_W-1:0]  SS_FIRST = 2'd0;

  // Field widths
  localparam int CHAN_W   = 8;
  localparam int NCHAN    = 4;
  localparam int RSUM_W   = 10;
  localparam int CSUM_W   = 12;
  localparam int OCOL_W   = 8;
  localparam int OROW_W   = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int OW_REG_W   = 9;
  localparam int OH_REG_W   = 11;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HEIGHT = 1'b1;

  localparam logic [OW_REG_W-1:0] OUTPUT_WIDTH_RST  = 9'd186;
  localparam logic [OH_REG_W-1:0] OUTPUT_HEIGHT_RST = 11'd329;

  typedef logic [CHAN_W-1:0]             chan_t;
  typedef logic [NCHAN-1:0][RSUM_W-1:0]  rsum_t;
  typedef logic [NCHAN-1:0][CSUM_W-1:0]  csum_t;

  typedef struct packed {
    chan_t             red;
    chan_t             green;
    chan_t             blue;
    chan_t             alpha;
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic              done;
  } result_t;

endpackage

/* rtl/box_downsample_rgba_4x4_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_rgba_4x4_unit
// Averages each 4x4 block of a raster RGBA sample stream into one pixel,
// rounding (sum + 8) / 16 per channel. Column sums live in a line store.
//
//   channel   handshake             payload
//   -------   -------------------   ---------------------------------------
//   input     in_valid / in_ready   sample_red/green/blue/alpha,
//                                   start_of_frame
//   output    out_valid / out_ready out_red/green/blue/alpha, out_col,
//                                   out_row, frame_done
//   config    cfg_we                cfg_index, cfg_data (no handshake)
//
// One request per clock while in_ready is high. A result is built from the
// bottom-right sample of its block by a line store read, then add and write
// back in stage 1, and is registered into a 2-entry output buffer; in_ready
// drops only while both entries are full. The line store has no clearing
// pass: it is ready at once after reset, and every entry is written by the
// first sub-row of a block before later sub-rows add to it.
// ----------------------------------------------------------------------------
module box_downsample_rgba_4x4_unit #(
  parameter int MAX_OUT_WIDTH  = bds_pkg::DEF_MAX_OUT_WIDTH,
  parameter int MAX_OUT_HEIGHT = bds_pkg::DEF_MAX_OUT_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [bds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0]  cfg_data,
  // sample requests
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bds_pkg::chan_t                  sample_red,
  input  bds_pkg::chan_t                  sample_green,
  input  bds_pkg::chan_t                  sample_blue,
  input  bds_pkg::chan_t                  sample_alpha,
  input  logic                            start_of_frame,
  // pixel results
  output logic                            out_valid,
  input  logic                            out_ready,
  output bds_pkg::chan_t                  out_red,
  output bds_pkg::chan_t                  out_green,
  output bds_pkg::chan_t                  out_blue,
  output bds_pkg::chan_t                  out_alpha,
  output logic [bds_pkg::OCOL_W-1:0]      out_col,
  output logic [bds_pkg::OROW_W-1:0]      out_row,
  output logic                            frame_done
);
  import bds_pkg::*;

  // Block counters index the store / count rows; size compares need one more
  localparam int CW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int RW = (MAX_OUT_HEIGHT > 1) ? $clog2(MAX_OUT_HEIGHT) : 1;
  localparam int WW = $clog2(MAX_OUT_WIDTH + 1);
  localparam int HW = $clog2(MAX_OUT_HEIGHT + 1);

  // Configuration registers
  logic [OW_REG_W-1:0] output_width;
  logic [OH_REG_W-1:0] output_height;

  // Position state
  logic [SS_W-1:0] sub_col, sub_row;
  logic [CW-1:0]   block_col;
  logic [RW-1:0]   block_row;
  rsum_t           row_partial;

  // Next values
  logic [SS_W-1:0] sub_col_next, sub_row_next;
  logic [CW-1:0]   block_col_next;
  logic [RW-1:0]   block_row_next;
  rsum_t           row_partial_next;

  // Stage 0 (accept) signals
  logic            in_fire;
  logic [SS_W-1:0] sc_c, sr_c;
  logic [CW-1:0]   bc_c;
  logic [RW-1:0]   br_c;
  logic [WW-1:0]   w_eff, bc_inc;
  logic [HW-1:0]   h_eff, br_inc;
  logic            col_end, col_wrap, row_wrap;
  chan_t [NCHAN-1:0] samp;

  // Line store
  csum_t           col_mem [MAX_OUT_WIDTH];
  csum_t           mem_q;

  // Stage 1 (add and write back)
  logic            s1_valid;
  logic            s1_first, s1_last, s1_done;
  logic [CW-1:0]   s1_addr;
  rsum_t           s1_rp;
  logic [OCOL_W-1:0] s1_col;
  logic [OROW_W-1:0] s1_row;
  csum_t           s1_sum;
  logic            s1_emit;
  result_t         s1_res;

  // Output buffer
  result_t         out_q, skid_q;
  logic            skid_valid;
  logic            pop;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      output_width  <= OUTPUT_WIDTH_RST;
      output_height <= OUTPUT_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUTPUT_WIDTH:  output_width  <= cfg_data[OW_REG_W-1:0];
        REG_OUTPUT_HEIGHT: output_height <= cfg_data[OH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (output_width == '0)                   w_eff = WW'(1);
    else if (32'(output_width) > MAX_OUT_WIDTH) w_eff = WW'(MAX_OUT_WIDTH);
    else                                      w_eff = WW'(output_width);
    if (output_height == '0)                    h_eff = HW'(1);
    else if (32'(output_height) > MAX_OUT_HEIGHT) h_eff = HW'(MAX_OUT_HEIGHT);
    else                                        h_eff = HW'(output_height);
  end

  assign in_fire = in_valid && in_ready;
  assign samp    = {sample_alpha, sample_blue, sample_green, sample_red};

  // Stage 0: resync on start of frame, build horizontal sums, advance position
  always_comb begin
    sc_c = start_of_frame ? '0 : sub_col;
    sr_c = start_of_frame ? '0 : sub_row;
    bc_c = start_of_frame ? '0 : block_col;
    br_c = start_of_frame ? '0 : block_row;

    for (int c = 0; c < NCHAN; c++) begin
      if (sc_c == SS_FIRST) row_partial_next[c] = RSUM_W'(samp[c]);
      else                  row_partial_next[c] = row_partial[c] + RSUM_W'(samp[c]);
    end

    col_end  = (sc_c == SS_LAST);
    bc_inc   = WW'(bc_c) + WW'(1);
    br_inc   = HW'(br_c) + HW'(1);
    col_wrap = (bc_inc >= w_eff);
    row_wrap = (br_inc >= h_eff);

    sub_col_next   = sc_c + SS_W'(1);
    block_col_next = bc_c;
    sub_row_next   = sr_c;
    block_row_next = br_c;
    if (col_end) begin
      block_col_next = col_wrap ? '0 : CW'(bc_inc);
      if (col_wrap) begin
        sub_row_next = sr_c + SS_W'(1);
        if (sr_c == SS_LAST) block_row_next = row_wrap ? '0 : RW'(br_inc);
      end
    end
  end

  // Hold position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_col   <= '0;
      sub_row   <= '0;
      block_col <= '0;
      block_row <= '0;
    end else if (in_fire) begin
      sub_col   <= sub_col_next;
      sub_row   <= sub_row_next;
      block_col <= block_col_next;
      block_row <= block_row_next;
    end
  end

  // Horizontal sum: the first sample of each group overwrites it
  always_ff @(posedge clk) begin
    if (in_fire) row_partial <= row_partial_next;
  end

  // Line store: read at the end of a horizontal group, write back in stage 1.
  // Two accesses to one entry are at least four requests apart, so the
  // write always lands before the next read of that entry.
  always_ff @(posedge clk) begin
    if (in_fire && col_end) mem_q <= col_mem[bc_c];
    if (s1_valid) col_mem[s1_addr] <= s1_sum;
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= in_fire && col_end;
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_fire && col_end) begin
      s1_first <= (sr_c == SS_FIRST);
      s1_last  <= (sr_c == SS_LAST);
      s1_addr  <= bc_c;
      s1_rp    <= row_partial_next;
      s1_col   <= OCOL_W'(bc_c);
      s1_row   <= OROW_W'(br_c);
      s1_done  <= col_wrap && row_wrap;
    end
  end

  // Start the column sum with the group or add the group into it, and round the block mean
  always_comb begin
    logic [CSUM_W:0]   rnd;
    logic [CHAN_W:0]   mean;
    chan_t [NCHAN-1:0] avg;
    for (int c = 0; c < NCHAN; c++) begin
      if (s1_first) s1_sum[c] = CSUM_W'(s1_rp[c]);
      else          s1_sum[c] = mem_q[c] + CSUM_W'(s1_rp[c]);
      rnd    = (CSUM_W+1)'(s1_sum[c]) + (CSUM_W+1)'(8);
      mean   = rnd[CSUM_W:4];
      avg[c] = mean[CHAN_W] ? '1 : mean[CHAN_W-1:0];
    end
    s1_emit      = s1_valid && s1_last;
    s1_res.red   = avg[0];
    s1_res.green = avg[1];
    s1_res.blue  = avg[2];
    s1_res.alpha = avg[3];
    s1_res.col   = s1_col;
    s1_res.row   = s1_row;
    s1_res.done  = s1_done;
  end

  // Output buffer: result register with one skid entry behind it
  assign pop      = out_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= s1_emit;
      end else begin
        out_valid  <= s1_emit;
      end
    end else if (s1_emit) begin
      if (out_valid) skid_valid <= 1'b1;
      else           out_valid  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_q <= skid_q;
        if (s1_emit) skid_q <= s1_res;
      end else if (s1_emit) begin
        out_q <= s1_res;
      end
    end else if (s1_emit) begin
      if (out_valid) skid_q <= s1_res;
      else           out_q  <= s1_res;
    end
  end

  assign out_red    = out_q.red;
  assign out_green  = out_q.green;
  assign out_blue   = out_q.blue;
  assign out_alpha  = out_q.alpha;
  assign out_col    = out_q.col;
  assign out_row    = out_q.row;
  assign frame_done = out_q.done;

endmodule

/* rtl/bds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_checker
// Port-level checks for the 4x4 box downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module bds_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input bds_pkg::chan_t                 out_red,
  input logic [bds_pkg::OCOL_W-1:0]     out_col,
  input logic [bds_pkg::OROW_W-1:0]     out_row,
  input logic                           frame_done
);
  import bds_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_col)
      && $stable(out_row) && $stable(frame_done))
    else $error("stalled result changed");

  // Drop request acceptance only while a result waits
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty output");

  // A fresh result traces back through stage 1 to an accepted request
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching request");

  // Clear results on reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind box_downsample_rgba_4x4_unit bds_checker u_bds_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_red        (out_red),
  .out_col        (out_col),
  .out_row        (out_row),
  .frame_done     (frame_done)
);
